// ===== rtl/core/cfl_pkg.sv =====
// Shared types and constants of the CFL time-step reducer.
`default_nettype none

package cfl_pkg;

    // Fixed-point formats
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int GAMMA_BITS = 19;
    localparam int CFL_BITS   = 17;

    // gamma * p and CFL * h both fit in this many bits, so the divider
    // only walks this many dividend bits
    localparam int DIV_BITS   = GAMMA_BITS + WORD_BITS;
    // Quotient limit before the sound-speed shift: (2^64 - 1) >> FRAC_BITS
    localparam int QLIM_BITS  = PROD_BITS - FRAC_BITS;
    // Partial remainder of the shared shift-subtract unit
    localparam int REM_BITS   = WORD_BITS + 3;
    localparam int CNT_BITS   = $clog2(DIV_BITS + 1);
    localparam int SQRT_STEPS = PROD_BITS / 2;

    // Configuration register map
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ADIABATIC_INDEX = 2'd0;
    localparam t_cfg_idx CFG_COURANT_NUMBER  = 2'd1;
    localparam t_cfg_idx CFG_CELL_SIZE       = 2'd2;

    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 19'd91750;
    localparam logic [CFL_BITS-1:0]   CFL_RESET   = 17'd32768;
    localparam logic [WORD_BITS-1:0]  H_RESET     = 32'd328;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK  = 2'd0;
    localparam t_status STATUS_BAD = 2'd1;
    localparam t_status STATUS_SAT = 2'd2;

    // Shared divide / square-root unit
    typedef enum logic {
        DSU_DIV,
        DSU_SQRT
    } t_dsu_op;

    typedef struct packed {
        logic    start;
        t_dsu_op op;
    } t_dsu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dsu_rsp;

    // Per-item sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_GP,
        ST_VN_GO,
        ST_VN_WAIT,
        ST_Q_GO,
        ST_Q_WAIT,
        ST_A_GO,
        ST_A_WAIT,
        ST_FINISH,
        ST_TAU_GO,
        ST_TAU_WAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/cfl_ifs.sv =====
// Valid/ready channel interfaces for cells in and time-step results out.
`default_nettype none

interface cfl_cell_if;
    logic                                  valid;
    logic                                  ready;
    logic        [cfl_pkg::WORD_BITS-1:0]  density;
    logic        [cfl_pkg::WORD_BITS-1:0]  pressure;
    logic signed [cfl_pkg::WORD_BITS-1:0]  vel_x;
    logic signed [cfl_pkg::WORD_BITS-1:0]  vel_y;
    logic signed [cfl_pkg::WORD_BITS-1:0]  vel_z;
    logic                                  last_cell;

    modport source (
        output valid, density, pressure, vel_x, vel_y, vel_z, last_cell,
        input  ready
    );
    modport sink (
        input  valid, density, pressure, vel_x, vel_y, vel_z, last_cell,
        output ready
    );
endinterface

interface cfl_result_if;
    logic                           valid;
    logic                           ready;
    logic [cfl_pkg::WORD_BITS-1:0]  time_step;
    logic [cfl_pkg::WORD_BITS-1:0]  max_speed;
    logic [1:0]                     status;

    modport source (
        output valid, time_step, max_speed, status,
        input  ready
    );
    modport sink (
        input  valid, time_step, max_speed, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/cfl_mul.sv =====
// Registered 32x32 unsigned multiplier shared by all products of the block.
`default_nettype none

module cfl_mul (
    input  wire logic                            i_clk,
    input  wire logic [cfl_pkg::WORD_BITS-1:0]   i_a,
    input  wire logic [cfl_pkg::WORD_BITS-1:0]   i_b,
    output logic      [cfl_pkg::PROD_BITS-1:0]   o_prod
);

    logic [cfl_pkg::PROD_BITS-1:0] w_full;
    logic [cfl_pkg::PROD_BITS-1:0] r_prod;

    assign w_full = {{cfl_pkg::WORD_BITS{1'b0}}, i_a} * {{cfl_pkg::WORD_BITS{1'b0}}, i_b};

    always_ff @(posedge i_clk) begin
        r_prod <= w_full;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/cfl_dsu.sv =====
// Shared shift-subtract unit: restoring division or integer square root, one bit a cycle.
`default_nettype none

module cfl_dsu (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire cfl_pkg::t_dsu_req                i_req,
    input  wire logic [cfl_pkg::PROD_BITS-1:0]    i_a,
    input  wire logic [cfl_pkg::WORD_BITS-1:0]    i_d,
    output cfl_pkg::t_dsu_rsp                     o_rsp,
    output logic      [cfl_pkg::DIV_BITS-1:0]     o_result
);

    localparam int PB = cfl_pkg::PROD_BITS;
    localparam int WB = cfl_pkg::WORD_BITS;
    localparam int DB = cfl_pkg::DIV_BITS;
    localparam int RB = cfl_pkg::REM_BITS;
    localparam int CB = cfl_pkg::CNT_BITS;

    logic                   r_busy;
    logic                   r_done;
    logic [CB-1:0]          r_cnt;
    cfl_pkg::t_dsu_op       r_op;
    logic [PB-1:0]          r_x;
    logic [WB-1:0]          r_d;
    logic [RB-1:0]          r_rem;
    logic [DB-1:0]          r_q;

    logic [RB-1:0]          w_shifted;
    logic [RB-1:0]          w_trial;
    logic [RB:0]            w_diff;
    logic                   w_ge;

    // One compare-subtract per cycle, shared by both operations
    always_comb begin
        unique case (r_op)
            cfl_pkg::DSU_SQRT: begin
                w_shifted = {r_rem[RB-3:0], r_x[PB-1:PB-2]};
                w_trial   = {1'b0, r_q[WB-1:0], 2'b01};
            end
            cfl_pkg::DSU_DIV: begin
                w_shifted = {r_rem[RB-2:0], r_x[PB-1]};
                w_trial   = {3'b000, r_d};
            end
            default: begin
                w_shifted = '0;
                w_trial   = '0;
            end
        endcase
        w_diff = {1'b0, w_shifted} - {1'b0, w_trial};
        w_ge   = ~w_diff[RB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == cfl_pkg::DSU_SQRT) ?
                          CB'(cfl_pkg::SQRT_STEPS) : CB'(DB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CB'(1);
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_d   <= i_d;
            r_rem <= '0;
            r_q   <= '0;
            // Dividend occupies only the low DIV_BITS; left-align it
            r_x   <= (i_req.op == cfl_pkg::DSU_SQRT) ?
                     i_a : {i_a[DB-1:0], {(PB-DB){1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[RB-1:0] : w_shifted;
            r_q   <= {r_q[DB-2:0], w_ge};
            r_x   <= (r_op == cfl_pkg::DSU_SQRT) ? (r_x << 2) : (r_x << 1);
        end
    end

    assign o_rsp    = {r_busy, r_done};
    assign o_result = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/cfl_time_step_reducer_top.sv =====
// CFL time-step reducer: per-cell signal speed, running maximum, time step on the last cell.
// Usage:
//   Cells enter on i_cell (valid/ready): density, pressure, vel_x/y/z (Q16.16) and
//   last_cell. A cell with rho != 0 yields |v| + sqrt(gamma*p/rho); a running max is kept.
//   A cell with last_cell set closes the set and one result leaves on o_result:
//   time_step = CFL*h/max_speed, max_speed and status (0 ok, 1 zero density seen,
//   2 saturated). Registers gamma, CFL and h are written on i_cfg_we/idx/data.
// Sequencing:
//   One registered multiplier and one shift-subtract unit do all arithmetic under a
//   small sequencer; ready is high only while the sequencer is idle.
//   A cell with nonzero density squares the velocities and forms gamma*p on the multiplier,
//   then runs a 32-step square root for |v|, a 51-step division for gamma*p/rho and a
//   32-step square root for the sound speed, each between a start and a wait state.
//   A zero-density cell skips this. A last cell then forms CFL*h, runs a 51-step division
//   (skipped if the set saw a zero density or has zero speed) and passes the hand-over
//   state; then the result lands in the output register.
// Reset and stall:
//   Synchronous active-low reset clears the set and restores the register defaults.
//   The output register holds a result until taken; new cells are still accepted
//   meanwhile, and the next result waits in the sequencer until the register frees.
`default_nettype none

module cfl_time_step_reducer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire cfl_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [cfl_pkg::WORD_BITS-1:0]    i_cfg_data,
    cfl_cell_if.sink                              i_cell,
    cfl_result_if.source                          o_result
);

    localparam int WB = cfl_pkg::WORD_BITS;
    localparam int PB = cfl_pkg::PROD_BITS;
    localparam int DB = cfl_pkg::DIV_BITS;
    localparam int QB = cfl_pkg::QLIM_BITS;
    localparam int FB = cfl_pkg::FRAC_BITS;
    localparam int GB = cfl_pkg::GAMMA_BITS;
    localparam int KB = cfl_pkg::CFL_BITS;

    function automatic logic [WB-1:0] f_mag(input logic [WB-1:0] v);
        logic [WB-1:0] neg;
        neg = ~v + WB'(1);
        return v[WB-1] ? neg : v;
    endfunction

    // Control state
    cfl_pkg::t_state        r_state;
    cfl_pkg::t_state        n_state;
    logic [GB-1:0]          r_gamma;
    logic [KB-1:0]          r_cfl;
    logic [WB-1:0]          r_h;
    logic [WB-1:0]          r_speed_max;
    logic                   r_bad;
    logic                   r_set_sat;
    logic                   r_out_valid;

    // Payload
    logic [WB-1:0]          r_rho;
    logic [WB-1:0]          r_p;
    logic [WB-1:0]          r_mx;
    logic [WB-1:0]          r_my;
    logic [WB-1:0]          r_mz;
    logic                   r_last;
    logic [PB-1:0]          r_acc;
    logic [DB-1:0]          r_gp;
    logic [WB-1:0]          r_vn;
    logic [WB-1:0]          r_tau;
    cfl_pkg::t_status       r_status;
    logic [WB-1:0]          r_out_tau;
    logic [WB-1:0]          r_out_speed;
    cfl_pkg::t_status       r_out_status;

    // Datapath wires
    logic [WB-1:0]          w_mul_a;
    logic [WB-1:0]          w_mul_b;
    logic [PB-1:0]          w_prod;
    cfl_pkg::t_dsu_req      w_dsu_req;
    cfl_pkg::t_dsu_rsp      w_dsu_rsp;
    logic [PB-1:0]          w_dsu_a;
    logic [WB-1:0]          w_dsu_d;
    logic [DB-1:0]          w_dsu_res;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_q_clamp;
    logic [QB-1:0]          w_q;
    logic [WB:0]            w_speed_sum;
    logic [WB-1:0]          w_speed;
    logic                   w_tau_sat;

    assign w_accept   = i_cell.valid && i_cell.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    // Quotient gamma*p/rho is clamped so the fraction shift cannot overflow
    assign w_q_clamp   = |w_dsu_res[DB-1:QB];
    assign w_q         = w_q_clamp ? {QB{1'b1}} : w_dsu_res[QB-1:0];
    assign w_speed_sum = {1'b0, r_vn} + {1'b0, w_dsu_res[WB-1:0]};
    assign w_speed     = w_speed_sum[WB] ? {WB{1'b1}} : w_speed_sum[WB-1:0];
    assign w_tau_sat   = |w_dsu_res[DB-1:WB];

    cfl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    cfl_dsu u_dsu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_dsu_req),
        .i_a      (w_dsu_a),
        .i_d      (w_dsu_d),
        .o_rsp    (w_dsu_rsp),
        .o_result (w_dsu_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_cell.density != '0) begin
                        n_state = cfl_pkg::ST_SQ_X;
                    end else if (i_cell.last_cell) begin
                        n_state = cfl_pkg::ST_FINISH;
                    end
                end
            end
            cfl_pkg::ST_SQ_X:    n_state = cfl_pkg::ST_SQ_Y;
            cfl_pkg::ST_SQ_Y:    n_state = cfl_pkg::ST_SQ_Z;
            cfl_pkg::ST_SQ_Z:    n_state = cfl_pkg::ST_GP;
            cfl_pkg::ST_GP:      n_state = cfl_pkg::ST_VN_GO;
            cfl_pkg::ST_VN_GO:   n_state = cfl_pkg::ST_VN_WAIT;
            cfl_pkg::ST_VN_WAIT: begin
                if (w_dsu_rsp.done) n_state = cfl_pkg::ST_Q_GO;
            end
            cfl_pkg::ST_Q_GO:    n_state = cfl_pkg::ST_Q_WAIT;
            cfl_pkg::ST_Q_WAIT: begin
                if (w_dsu_rsp.done) n_state = cfl_pkg::ST_A_GO;
            end
            cfl_pkg::ST_A_GO:    n_state = cfl_pkg::ST_A_WAIT;
            cfl_pkg::ST_A_WAIT: begin
                if (w_dsu_rsp.done) begin
                    n_state = r_last ? cfl_pkg::ST_FINISH : cfl_pkg::ST_IDLE;
                end
            end
            cfl_pkg::ST_FINISH: begin
                if (r_bad || r_speed_max == '0) begin
                    n_state = cfl_pkg::ST_DONE;
                end else begin
                    n_state = cfl_pkg::ST_TAU_GO;
                end
            end
            cfl_pkg::ST_TAU_GO:  n_state = cfl_pkg::ST_TAU_WAIT;
            cfl_pkg::ST_TAU_WAIT: begin
                if (w_dsu_rsp.done) n_state = cfl_pkg::ST_DONE;
            end
            cfl_pkg::ST_DONE: begin
                if (w_out_free) n_state = cfl_pkg::ST_IDLE;
            end
            default:             n_state = cfl_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and divide/sqrt requests
    always_comb begin
        w_mul_a         = '0;
        w_mul_b         = '0;
        w_dsu_req.start = 1'b0;
        w_dsu_req.op    = cfl_pkg::DSU_DIV;
        w_dsu_a         = '0;
        w_dsu_d         = '0;
        unique case (r_state)
            cfl_pkg::ST_SQ_X: begin
                w_mul_a = r_mx;
                w_mul_b = r_mx;
            end
            cfl_pkg::ST_SQ_Y: begin
                w_mul_a = r_my;
                w_mul_b = r_my;
            end
            cfl_pkg::ST_SQ_Z: begin
                w_mul_a = r_mz;
                w_mul_b = r_mz;
            end
            cfl_pkg::ST_GP: begin
                w_mul_a = {{(WB-GB){1'b0}}, r_gamma};
                w_mul_b = r_p;
            end
            cfl_pkg::ST_VN_GO: begin
                w_dsu_req.start = 1'b1;
                w_dsu_req.op    = cfl_pkg::DSU_SQRT;
                w_dsu_a         = r_acc;
            end
            cfl_pkg::ST_Q_GO: begin
                w_dsu_req.start = 1'b1;
                w_dsu_req.op    = cfl_pkg::DSU_DIV;
                w_dsu_a         = {{(PB-DB){1'b0}}, r_gp};
                w_dsu_d         = r_rho;
            end
            cfl_pkg::ST_A_GO: begin
                w_dsu_req.start = 1'b1;
                w_dsu_req.op    = cfl_pkg::DSU_SQRT;
                w_dsu_a         = r_acc;
            end
            cfl_pkg::ST_FINISH: begin
                w_mul_a = {{(WB-KB){1'b0}}, r_cfl};
                w_mul_b = r_h;
            end
            cfl_pkg::ST_TAU_GO: begin
                w_dsu_req.start = 1'b1;
                w_dsu_req.op    = cfl_pkg::DSU_DIV;
                w_dsu_a         = {{(PB-DB){1'b0}}, w_prod[DB-1:0]};
                w_dsu_d         = r_speed_max;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfl_pkg::ST_IDLE;
            r_gamma     <= cfl_pkg::GAMMA_RESET;
            r_cfl       <= cfl_pkg::CFL_RESET;
            r_h         <= cfl_pkg::H_RESET;
            r_speed_max <= '0;
            r_bad       <= 1'b0;
            r_set_sat   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cfl_pkg::CFG_ADIABATIC_INDEX: r_gamma <= i_cfg_data[GB-1:0];
                    cfl_pkg::CFG_COURANT_NUMBER:  r_cfl   <= i_cfg_data[KB-1:0];
                    cfl_pkg::CFG_CELL_SIZE:       r_h     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == cfl_pkg::ST_IDLE && w_accept && i_cell.density == '0) begin
                r_bad <= 1'b1;
            end

            if (r_state == cfl_pkg::ST_Q_WAIT && w_dsu_rsp.done && w_q_clamp) begin
                r_set_sat <= 1'b1;
            end

            if (r_state == cfl_pkg::ST_A_WAIT && w_dsu_rsp.done) begin
                if (w_speed_sum[WB]) begin
                    r_set_sat <= 1'b1;
                end
                if (w_speed > r_speed_max) begin
                    r_speed_max <= w_speed;
                end
            end

            // Hand the result to the output register and open a new set
            if (r_state == cfl_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_speed_max <= '0;
                r_bad       <= 1'b0;
                r_set_sat   <= 1'b0;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rho  <= i_cell.density;
            r_p    <= i_cell.pressure;
            r_mx   <= f_mag(i_cell.vel_x);
            r_my   <= f_mag(i_cell.vel_y);
            r_mz   <= f_mag(i_cell.vel_z);
            r_last <= i_cell.last_cell;
        end

        unique case (r_state)
            cfl_pkg::ST_SQ_Y: r_acc <= w_prod;
            cfl_pkg::ST_SQ_Z: r_acc <= r_acc + w_prod;
            cfl_pkg::ST_GP:   r_acc <= r_acc + w_prod;
            cfl_pkg::ST_VN_GO: r_gp <= w_prod[DB-1:0];
            cfl_pkg::ST_VN_WAIT: begin
                if (w_dsu_rsp.done) r_vn <= w_dsu_res[WB-1:0];
            end
            cfl_pkg::ST_Q_WAIT: begin
                // Sound-speed radicand: clamped quotient shifted up by the fraction
                if (w_dsu_rsp.done) r_acc <= {w_q, {FB{1'b0}}};
            end
            cfl_pkg::ST_FINISH: begin
                if (r_bad) begin
                    r_tau    <= '0;
                    r_status <= cfl_pkg::STATUS_BAD;
                end else if (r_speed_max == '0) begin
                    r_tau    <= {WB{1'b1}};
                    r_status <= cfl_pkg::STATUS_SAT;
                end
            end
            cfl_pkg::ST_TAU_WAIT: begin
                if (w_dsu_rsp.done) begin
                    r_tau    <= w_tau_sat ? {WB{1'b1}} : w_dsu_res[WB-1:0];
                    r_status <= (w_tau_sat || r_set_sat) ?
                                cfl_pkg::STATUS_SAT : cfl_pkg::STATUS_OK;
                end
            end
            cfl_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_out_tau    <= r_tau;
                    r_out_speed  <= r_speed_max;
                    r_out_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_cell.ready       = (r_state == cfl_pkg::ST_IDLE);
    assign o_result.valid     = r_out_valid;
    assign o_result.time_step = r_out_tau;
    assign o_result.max_speed = r_out_speed;
    assign o_result.status    = r_out_status;

endmodule

`default_nettype wire
